[rtl/lre_pkg.sv]
`timescale 1ns / 1ps

package lre_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned NOTICE_W  = 2;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned PERIOD_W  = 7;
  localparam int unsigned SEC_W     = 12;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned BIT_IDX_W = $clog2(COUNT_W);

  localparam logic [OP_W-1:0] OP_START        = 3'd0;
  localparam logic [OP_W-1:0] OP_DISCONNECTED = 3'd1;
  localparam logic [OP_W-1:0] OP_ADDR_LOST    = 3'd2;
  localparam logic [OP_W-1:0] OP_ADDR_GOT     = 3'd3;
  localparam logic [OP_W-1:0] OP_TIMER        = 3'd4;

  localparam logic [NOTICE_W-1:0] NOTICE_NONE = 2'd0;
  localparam logic [NOTICE_W-1:0] NOTICE_DOWN = 2'd1;
  localparam logic [NOTICE_W-1:0] NOTICE_UP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SETUP_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_SEC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FAST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SLOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LONG    = 3'd6;

  localparam logic [PERIOD_W-1:0] RST_FAST_LIMIT    = 7'd5;
  localparam logic [PERIOD_W-1:0] RST_BOUNCE_PERIOD = 7'd20;
  localparam logic [SEC_W-1:0]    RST_REBOOT_SEC    = 12'd600;
  localparam logic [DELAY_W-1:0]  RST_DELAY_FAST    = 16'd1000;
  localparam logic [DELAY_W-1:0]  RST_DELAY_SLOW    = 16'd5000;
  localparam logic [DELAY_W-1:0]  RST_DELAY_LONG    = 16'd10000;

  localparam logic [19:0]      US_PER_SEC     = 20'd1000000;
  localparam logic [THR_W-1:0] RST_REBOOT_THR = THR_W'(600 * 1000000);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

[rtl/link_reconnect_escalation_core.sv]
`timescale 1ns / 1ps
// A request passes through the input register and the result register before its result is valid.
// Throughput: one request per cycle while the result side is not stalled and no phase rebuild runs.
// A write to bounce_period starts a pass that rebuilds the bounce phase one retry-count bit at a
// time (a zero period ends it at its first step); in_stall is high during it.
// Reset (rst, synchronous): registers at their defaults, retry count, phase and
// down time cleared, pipeline empty.
module link_reconnect_escalation_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lre_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lre_pkg::OP_W-1:0]           operation,
  input  logic                               connect_ok,
  input  logic [lre_pkg::TIME_W-1:0]         now_us,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lre_pkg::NOTICE_W-1:0]       network_notice,
  output logic                               disconnect_first,
  output logic                               do_connect,
  output logic                               bounce_driver,
  output logic                               reboot,
  output logic                               schedule_retry,
  output logic [lre_pkg::DELAY_W-1:0]        retry_delay_ms,
  output logic [lre_pkg::COUNT_W-1:0]        retry_count
);

  // configuration
  logic                              setup_mode;
  logic [lre_pkg::PERIOD_W-1:0]      fast_retry_limit;
  logic [lre_pkg::PERIOD_W-1:0]      bounce_period;
  logic [lre_pkg::THR_W-1:0]         reboot_thr_us;
  logic [lre_pkg::DELAY_W-1:0]       delay_fast_ms;
  logic [lre_pkg::DELAY_W-1:0]       delay_slow_ms;
  logic [lre_pkg::DELAY_W-1:0]       delay_long_ms;

  // state
  logic [lre_pkg::COUNT_W-1:0]       retries;
  logic [lre_pkg::PERIOD_W-1:0]      bounce_phase;
  logic [lre_pkg::TIME_W-1:0]        down_since_us;

  // phase rebuild
  logic                              busy;
  logic [lre_pkg::BIT_IDX_W-1:0]     bit_idx;
  logic [lre_pkg::PERIOD_W:0]        rem;
  logic [lre_pkg::PERIOD_W:0]        rem_shift;
  logic [lre_pkg::PERIOD_W:0]        rem_next;

  // input register
  logic                              s1_valid;
  logic [lre_pkg::OP_W-1:0]          s1_op;
  logic                              s1_ok;
  logic [lre_pkg::TIME_W-1:0]        s1_now;

  logic adv2;
  logic adv1;
  logic fire2;

  // step logic
  logic [lre_pkg::NOTICE_W-1:0]      notice_next;
  logic                              disc_next;
  logic                              conn_next;
  logic                              bounce_next;
  logic                              rb_next;
  logic                              sched_next;
  logic [lre_pkg::DELAY_W-1:0]       delay_next;
  logic [lre_pkg::COUNT_W-1:0]       retries_next;
  logic [lre_pkg::PERIOD_W-1:0]      phase_next;
  logic [lre_pkg::TIME_W-1:0]        down_next;

  logic                              bump;
  logic                              can_bump;
  logic [lre_pkg::COUNT_W-1:0]       retries_inc;
  logic [lre_pkg::PERIOD_W-1:0]      phase_inc;
  logic [lre_pkg::TIME_W-1:0]        down_marked;
  logic [lre_pkg::TIME_W-1:0]        elapsed;
  logic                              reboot_due;
  logic                              bounce_due;
  logic [lre_pkg::DELAY_W-1:0]       tier_delay;

  assign adv2     = !out_valid || !out_stall;
  assign adv1     = !s1_valid || adv2;
  assign fire2    = s1_valid && adv2;
  assign in_stall = busy || !adv1;

  assign rem_shift = {rem[lre_pkg::PERIOD_W-1:0], retries[bit_idx]};
  assign rem_next  = (rem_shift >= {1'b0, bounce_period})
                   ? rem_shift - {1'b0, bounce_period} : rem_shift;

  always_comb begin
    can_bump    = retries != lre_pkg::COUNT_MAX;
    retries_inc = retries + lre_pkg::COUNT_W'(1);
    if (bounce_period == '0) begin
      phase_inc = '0;
    end else if (bounce_phase + lre_pkg::PERIOD_W'(1) == bounce_period) begin
      phase_inc = '0;
    end else begin
      phase_inc = bounce_phase + lre_pkg::PERIOD_W'(1);
    end
    down_marked = (down_since_us == '0) ? s1_now : down_since_us;
    elapsed     = s1_now - down_since_us;
    reboot_due  = (down_since_us != '0) && (s1_now >= down_since_us)
               && (elapsed >= {{(lre_pkg::TIME_W-lre_pkg::THR_W){1'b0}}, reboot_thr_us});
    bounce_due  = (retries != '0) && (bounce_period != '0) && (bounce_phase == '0);

    notice_next  = lre_pkg::NOTICE_NONE;
    disc_next    = 1'b0;
    conn_next    = 1'b0;
    bounce_next  = 1'b0;
    rb_next      = 1'b0;
    sched_next   = 1'b0;
    bump         = 1'b0;
    retries_next = retries;
    phase_next   = bounce_phase;
    down_next    = down_since_us;

    case (s1_op)
      lre_pkg::OP_START: begin
        conn_next  = 1'b1;
        sched_next = !s1_ok;
      end
      lre_pkg::OP_DISCONNECTED: begin
        notice_next = lre_pkg::NOTICE_DOWN;
        down_next   = down_marked;
        bump        = 1'b1;
        sched_next  = 1'b1;
      end
      lre_pkg::OP_ADDR_LOST: begin
        notice_next = lre_pkg::NOTICE_DOWN;
        down_next   = down_marked;
        disc_next   = 1'b1;
        sched_next  = 1'b1;
      end
      lre_pkg::OP_ADDR_GOT: begin
        notice_next  = lre_pkg::NOTICE_UP;
        retries_next = '0;
        phase_next   = '0;
        down_next    = '0;
      end
      lre_pkg::OP_TIMER: begin
        if (!setup_mode) begin
          if (reboot_due) begin
            rb_next = 1'b1;
          end else if (bounce_due) begin
            bounce_next = 1'b1;
          end else begin
            disc_next  = retries > {{(lre_pkg::COUNT_W-lre_pkg::PERIOD_W){1'b0}},
                                    fast_retry_limit};
            conn_next  = 1'b1;
            bump       = !s1_ok;
            sched_next = !s1_ok;
          end
        end
      end
      default: begin
      end
    endcase

    if (bump && can_bump) begin
      retries_next = retries_inc;
      phase_next   = phase_inc;
    end

    // tier uses the count after this event
    if (retries_next < {{(lre_pkg::COUNT_W-lre_pkg::PERIOD_W){1'b0}}, fast_retry_limit}) begin
      tier_delay = delay_fast_ms;
    end else if (retries_next <
                 {{(lre_pkg::COUNT_W-lre_pkg::PERIOD_W){1'b0}}, bounce_period}) begin
      tier_delay = delay_slow_ms;
    end else begin
      tier_delay = delay_long_ms;
    end

    if (!sched_next) begin
      delay_next = '0;
    end else if (s1_op == lre_pkg::OP_START || s1_op == lre_pkg::OP_ADDR_LOST) begin
      delay_next = delay_fast_ms;
    end else begin
      delay_next = tier_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_mode       <= 1'b0;
      fast_retry_limit <= lre_pkg::RST_FAST_LIMIT;
      bounce_period    <= lre_pkg::RST_BOUNCE_PERIOD;
      reboot_thr_us    <= lre_pkg::RST_REBOOT_THR;
      delay_fast_ms    <= lre_pkg::RST_DELAY_FAST;
      delay_slow_ms    <= lre_pkg::RST_DELAY_SLOW;
      delay_long_ms    <= lre_pkg::RST_DELAY_LONG;
      busy             <= 1'b0;
      bit_idx          <= '0;
      rem              <= '0;
      retries          <= '0;
      bounce_phase     <= '0;
      down_since_us    <= '0;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lre_pkg::REG_SETUP_MODE:    setup_mode       <= cfg_data[0];
          lre_pkg::REG_FAST_LIMIT:    fast_retry_limit <= cfg_data[lre_pkg::PERIOD_W-1:0];
          lre_pkg::REG_BOUNCE_PERIOD: bounce_period    <= cfg_data[lre_pkg::PERIOD_W-1:0];
          lre_pkg::REG_REBOOT_SEC:    reboot_thr_us    <= lre_pkg::THR_W'(
                                        cfg_data[lre_pkg::SEC_W-1:0] * lre_pkg::US_PER_SEC);
          lre_pkg::REG_DELAY_FAST:    delay_fast_ms    <= cfg_data;
          lre_pkg::REG_DELAY_SLOW:    delay_slow_ms    <= cfg_data;
          lre_pkg::REG_DELAY_LONG:    delay_long_ms    <= cfg_data;
          default: begin
          end
        endcase
      end

      // rebuild phase = retries mod period, one bit per cycle, msb first
      if (cfg_we && cfg_index == lre_pkg::REG_BOUNCE_PERIOD) begin
        busy    <= 1'b1;
        bit_idx <= lre_pkg::BIT_IDX_W'(lre_pkg::COUNT_W - 1);
        rem     <= '0;
      end else if (busy) begin
        if (bounce_period == '0) begin
          busy         <= 1'b0;
          bounce_phase <= '0;
        end else if (bit_idx == '0) begin
          busy         <= 1'b0;
          bounce_phase <= rem_next[lre_pkg::PERIOD_W-1:0];
        end else begin
          bit_idx <= bit_idx - lre_pkg::BIT_IDX_W'(1);
          rem     <= rem_next;
        end
      end

      if (adv1) begin
        s1_valid <= in_valid && !busy;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
      if (fire2) begin
        retries       <= retries_next;
        bounce_phase  <= phase_next;
        down_since_us <= down_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op  <= operation;
      s1_ok  <= connect_ok;
      s1_now <= now_us;
    end
    if (fire2) begin
      network_notice   <= notice_next;
      disconnect_first <= disc_next;
      do_connect       <= conn_next;
      bounce_driver    <= bounce_next;
      reboot           <= rb_next;
      schedule_retry   <= sched_next;
      retry_delay_ms   <= delay_next;
      retry_count      <= retries_next;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("request taken during phase rebuild");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    !busy && bounce_period != '0 |-> bounce_phase < bounce_period)
    else $error("bounce phase out of range");

  a_phase_zero: assert property (@(posedge clk) disable iff (rst)
    !busy && bounce_period == '0 |-> bounce_phase == '0)
    else $error("bounce phase nonzero with zero period");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> retry_count == retries)
    else $error("result count differs from state");

  a_up_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && network_notice == lre_pkg::NOTICE_UP |-> down_since_us == '0)
    else $error("link up with down time latched");

  a_reboot_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && reboot |-> !schedule_retry && !do_connect && !bounce_driver)
    else $error("reboot combined with other actions");

endmodule
